// ----- hdl/asc_pkg.sv -----
// asc_pkg: shared codes, widths and constants of the actuator step controller
// used by asc_step_math and actuator_step_controller_core; no dependencies
package asc_pkg;

	// field widths of the ports
	localparam int FUNC_W  = 2;
	localparam int MODE_W  = 2;
	localparam int CLASS_W = 3;
	localparam int ACLS_W  = 2;
	localparam int TAG_W   = 32;
	localparam int TIME_W  = 64;
	localparam int ERR_W   = 3;
	localparam int DRIVE_W = 11;
	localparam int POS_W   = 16;

	// default for the frame id compare width
	localparam int FRAME_WIDTH_DEF = 32;

	// internal width of the step arithmetic: target minus position and the new sum
	localparam int MATH_W = 18;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNK   = 2'd3;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_FIXED      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLASSIFIER = 2'd1;

	// class codes
	localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_LEFT    = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_CENTER  = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_RIGHT   = 3'd3;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
	localparam logic [ERR_W-1:0] ERR_STATE = 3'd1;
	localparam logic [ERR_W-1:0] ERR_MODE  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_CLASS = 3'd3;
	localparam logic [ERR_W-1:0] ERR_CMD   = 3'd4;

	// step constants
	localparam int TGT_LEFT    = -20000;
	localparam int TGT_RIGHT   = 20000;
	localparam int DRIVE_LIMIT = 1000;
	localparam int POS_STEP    = 4;
	localparam int DRIVE_DIV   = 16;
	localparam int POS_SHIFT   = $clog2(POS_STEP);
	localparam int DIV_SHIFT   = $clog2(DRIVE_DIV);
	localparam int POS_MAX     = 32767;
	localparam int POS_MIN     = -32768;

endpackage

// ----- hdl/asc_step_math.sv -----
// asc_step_math: drive and next position of one step toward a class target
// depends on asc_pkg for widths and step constants
module asc_step_math (
	input  logic        [asc_pkg::ACLS_W-1:0]  cls,
	input  logic signed [asc_pkg::POS_W-1:0]   pos,
	output logic signed [asc_pkg::DRIVE_W-1:0] drive,
	output logic signed [asc_pkg::POS_W-1:0]   pos_next
);

	localparam int W = asc_pkg::MATH_W;

	logic signed [W-1:0] target;
	logic signed [W-1:0] diff;
	logic signed [W-1:0] biased;
	logic signed [W-1:0] quo;
	logic signed [W-1:0] drv_clamped;
	logic signed [W-1:0] sum;

	// target of the applied class
	always_comb begin
		case (cls)
			asc_pkg::CLS_LEFT[asc_pkg::ACLS_W-1:0]:  target = W'(asc_pkg::TGT_LEFT);
			asc_pkg::CLS_RIGHT[asc_pkg::ACLS_W-1:0]: target = W'(asc_pkg::TGT_RIGHT);
			default:                                 target = '0;
		endcase
	end

	// divide by a power of two, truncating toward zero
	always_comb begin
		diff   = target - W'(pos);
		biased = diff + (diff[W-1] ? W'(asc_pkg::DRIVE_DIV - 1) : W'(0));
		quo    = biased >>> asc_pkg::DIV_SHIFT;
	end

	// clamp the drive
	always_comb begin
		if (quo > W'(asc_pkg::DRIVE_LIMIT)) begin
			drv_clamped = W'(asc_pkg::DRIVE_LIMIT);
		end else if (quo < W'(-asc_pkg::DRIVE_LIMIT)) begin
			drv_clamped = W'(-asc_pkg::DRIVE_LIMIT);
		end else begin
			drv_clamped = quo;
		end
		drive = drv_clamped[asc_pkg::DRIVE_W-1:0];
	end

	// move the position and saturate to the position range
	always_comb begin
		sum = W'(pos) + (drv_clamped <<< asc_pkg::POS_SHIFT);
		if (sum > W'(asc_pkg::POS_MAX)) begin
			pos_next = asc_pkg::POS_W'(asc_pkg::POS_MAX);
		end else if (sum < W'(asc_pkg::POS_MIN)) begin
			pos_next = asc_pkg::POS_W'(asc_pkg::POS_MIN);
		end else begin
			pos_next = sum[asc_pkg::POS_W-1:0];
		end
	end

endmodule

// ----- hdl/actuator_step_controller_core.sv -----
// actuator_step_controller_core: command-driven one-axis actuator stepper
// depends on asc_pkg and asc_step_math
//
// channel | direction | handshake            | word
// --------+-----------+----------------------+-----------------------------------------
// in      | to core   | in_valid / in_stall  | func, mode, class_in, frame_tag, sent_time
// out     | from core | out_valid / out_stall| error_code .. duplicate (one per command)
//
// each command passes through the input register, then its decode and step math land in
// the output register as its status word. a new command is taken every cycle unless
// a full output register is stalled; the position and cache registers are
// updated when a command moves into the output register, so the next one sees them.
// out_stall holds the output register and backs up into in_stall within the cycle.
// arst_n clears the valid flags, the position, the halt flag and the cache.
module actuator_step_controller_core #(
	parameter int FRAME_WIDTH = asc_pkg::FRAME_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic        [asc_pkg::FUNC_W-1:0]   func,
	input  logic        [asc_pkg::MODE_W-1:0]   mode,
	input  logic        [asc_pkg::CLASS_W-1:0]  class_in,
	input  logic        [asc_pkg::TAG_W-1:0]    frame_tag,
	input  logic        [asc_pkg::TIME_W-1:0]   sent_time,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [asc_pkg::ERR_W-1:0]    error_code,
	output logic                                status_valid,
	output logic                                run_status,
	output logic        [asc_pkg::ACLS_W-1:0]   class_used,
	output logic        [asc_pkg::TAG_W-1:0]    frame_echo,
	output logic signed [asc_pkg::DRIVE_W-1:0]  drive,
	output logic signed [asc_pkg::POS_W-1:0]    position,
	output logic        [asc_pkg::TIME_W-1:0]   time_echo,
	output logic                                duplicate
);

	// frame ids compare on the low bits only
	localparam int TagW = (FRAME_WIDTH < asc_pkg::TAG_W) ? FRAME_WIDTH : asc_pkg::TAG_W;

	// input register
	logic                          valid_s1;
	logic [asc_pkg::FUNC_W-1:0]    func_s1;
	logic [asc_pkg::MODE_W-1:0]    mode_s1;
	logic [asc_pkg::CLASS_W-1:0]   class_s1;
	logic [TagW-1:0]               tag_s1;
	logic [asc_pkg::TIME_W-1:0]    time_s1;

	// output register
	logic                          valid_s2;

	// controller state
	logic signed [asc_pkg::POS_W-1:0]   pos_q;
	logic                               halted_q;
	logic                               cache_valid_q;
	logic [TagW-1:0]                    last_frame_q;
	logic [asc_pkg::ACLS_W-1:0]         cached_class_q;
	logic signed [asc_pkg::DRIVE_W-1:0] cached_drive_q;
	logic signed [asc_pkg::POS_W-1:0]   cached_pos_q;
	logic [asc_pkg::TIME_W-1:0]         cached_time_q;

	// handshake
	logic in_acc;
	logic advance;
	logic take;

	// decode results
	logic [asc_pkg::ERR_W-1:0]          res_err;
	logic                               res_run;
	logic [asc_pkg::ACLS_W-1:0]         res_cls;
	logic [asc_pkg::TAG_W-1:0]          res_frame;
	logic signed [asc_pkg::DRIVE_W-1:0] res_drive;
	logic signed [asc_pkg::POS_W-1:0]   res_pos;
	logic [asc_pkg::TIME_W-1:0]         res_time;
	logic                               res_dup;
	logic                               do_reset;
	logic                               do_stop;
	logic                               do_step;

	logic [asc_pkg::TAG_W-1:0]          tag_ext;
	logic [asc_pkg::TAG_W-1:0]          last_ext;
	logic [asc_pkg::ACLS_W-1:0]         step_cls;
	logic signed [asc_pkg::DRIVE_W-1:0] step_drive;
	logic signed [asc_pkg::POS_W-1:0]   step_pos;

	// flow control
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;
	assign take     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= func;
			mode_s1  <= mode;
			class_s1 <= class_in;
			tag_s1   <= frame_tag[TagW-1:0];
			time_s1  <= sent_time;
		end
	end

	// zero-extended frame ids for the status word
	always_comb begin
		tag_ext  = '0;
		last_ext = '0;
		tag_ext[TagW-1:0]  = tag_s1;
		last_ext[TagW-1:0] = last_frame_q;
	end

	// class applied by a step: fixed mode always centers
	assign step_cls = (mode_s1 == asc_pkg::MODE_FIXED)
		? asc_pkg::CLS_CENTER[asc_pkg::ACLS_W-1:0]
		: class_s1[asc_pkg::ACLS_W-1:0];

	asc_step_math u_math (
		.cls      (step_cls),
		.pos      (pos_q),
		.drive    (step_drive),
		.pos_next (step_pos)
	);

	// command decode, checks in priority order
	always_comb begin
		res_err   = asc_pkg::ERR_OK;
		res_run   = 1'b0;
		res_cls   = '0;
		res_frame = '0;
		res_drive = '0;
		res_pos   = '0;
		res_time  = '0;
		res_dup   = 1'b0;
		do_reset  = 1'b0;
		do_stop   = 1'b0;
		do_step   = 1'b0;
		if (mode_s1 > asc_pkg::MODE_CLASSIFIER) begin
			res_err = asc_pkg::ERR_MODE;
		end else if (class_s1 > asc_pkg::CLS_RIGHT) begin
			res_err = asc_pkg::ERR_CLASS;
		end else begin
			unique case (func_s1)
				asc_pkg::FUNC_RESET: begin
					res_cls   = asc_pkg::CLS_CENTER[asc_pkg::ACLS_W-1:0];
					res_frame = tag_ext;
					res_time  = time_s1;
					do_reset  = 1'b1;
				end
				asc_pkg::FUNC_STEP: begin
					if (halted_q) begin
						res_err = asc_pkg::ERR_STATE;
					end else if (cache_valid_q && tag_s1 == last_frame_q) begin
						// repeated frame: replay the cached status
						res_cls   = cached_class_q;
						res_frame = last_ext;
						res_drive = cached_drive_q;
						res_pos   = cached_pos_q;
						res_time  = cached_time_q;
						res_dup   = 1'b1;
					end else if (mode_s1 == asc_pkg::MODE_CLASSIFIER &&
						class_s1 == asc_pkg::CLS_UNKNOWN) begin
						res_err = asc_pkg::ERR_CLASS;
					end else begin
						res_cls   = step_cls;
						res_frame = tag_ext;
						res_drive = step_drive;
						res_pos   = step_pos;
						res_time  = time_s1;
						do_step   = 1'b1;
					end
				end
				asc_pkg::FUNC_STOP: begin
					res_run   = 1'b1;
					res_cls   = asc_pkg::CLS_CENTER[asc_pkg::ACLS_W-1:0];
					res_frame = tag_ext;
					res_pos   = pos_q;
					res_time  = time_s1;
					do_stop   = 1'b1;
				end
				default: begin
					res_err = asc_pkg::ERR_CMD;
				end
			endcase
		end
	end

	// controller state, updated as a command enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			halted_q       <= 1'b0;
			cache_valid_q  <= 1'b0;
			last_frame_q   <= '0;
			cached_class_q <= '0;
			cached_drive_q <= '0;
			cached_pos_q   <= '0;
			cached_time_q  <= '0;
		end else if (take) begin
			if (do_reset) begin
				pos_q          <= '0;
				halted_q       <= 1'b0;
				cache_valid_q  <= 1'b0;
				last_frame_q   <= '0;
				cached_class_q <= '0;
				cached_drive_q <= '0;
				cached_pos_q   <= '0;
				cached_time_q  <= '0;
			end else if (do_stop) begin
				halted_q <= 1'b1;
			end else if (do_step) begin
				pos_q          <= step_pos;
				cache_valid_q  <= 1'b1;
				last_frame_q   <= tag_s1;
				cached_class_q <= step_cls;
				cached_drive_q <= step_drive;
				cached_pos_q   <= step_pos;
				cached_time_q  <= time_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			error_code    <= res_err;
			status_valid  <= (res_err == asc_pkg::ERR_OK);
			run_status    <= res_run;
			class_used    <= res_cls;
			frame_echo    <= res_frame;
			drive         <= res_drive;
			position      <= res_pos;
			time_echo     <= res_time;
			duplicate     <= res_dup;
		end
	end

	assign out_valid = valid_s2;

endmodule
